FILE: hw/rtl/krt_pkg.sv
// Shared types and constants of the keyed record table.
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SLOT_W   = 6;
   localparam int LIST_MAX = 64;
   localparam int LIST_W   = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_LIST   = 3'd1;
   localparam logic [2:0] KIND_SEARCH = 3'd2;
   localparam logic [2:0] KIND_UPDATE = 3'd3;
   localparam logic [2:0] KIND_DELETE = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] record_key;
      logic [63:0]        name_tag;
      logic signed [31:0] amount;
      logic [31:0]        price_word;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         slot;
      logic signed [31:0] out_key;
      logic [63:0]        out_name;
      logic signed [31:0] out_amount;
      logic [31:0]        out_price;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name;
      logic signed [31:0] amount;
      logic [31:0]        price;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      rec_type          wr_data;
   } ram_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/krt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module krt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/krt_seq.sv
// Sequencer of the record table: request latch, key compare, fill count, RAM control.
`timescale 1ns / 1ps
`default_nettype none

module krt_seq
   import krt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   input  wire req_type req_data,
   input  wire logic   out_free,
   output logic        rsp_load,
   output rsp_type     rsp_next,
   output ram_ctl_type ram_ctl,
   input  wire rec_type ram_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_STATUS,
      S_ADD,
      S_LIST_RD,
      S_LIST_WAIT,
      S_SCAN,
      S_HIT,
      S_SHIFT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   req_type          req_ff, req_in;
   logic [1:0]       status_ff, status_in;

   logic              key_hit;
   logic              list_last;
   logic [CNT_W:0]    shift_next;
   logic [CNT_W-1:0]  next_pos;

   assign key_hit    = pend_ff && (ram_rd_data.key == req_ff.record_key);
   assign list_last  = ((LIST_W'(idx_ff) + LIST_W'(1)) == LIST_W'(fill_ff))
                       || (LIST_W'(idx_ff) == LIST_W'(LIST_MAX - 1));
   assign shift_next = (CNT_W+1)'(idx_ff) + (CNT_W+1)'(2);
   assign next_pos   = idx_ff + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      req_in    = req_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      ram_ctl   = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req_data;
               idx_in  = '0;
               pend_in = 1'b0;
               unique case (req_data.kind) inside
                  KIND_ADD: begin
                     if (fill_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                        state_in  = S_STATUS;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  KIND_LIST: begin
                     if (fill_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_STATUS;
                     end else begin
                        state_in = S_LIST_RD;
                     end
                  end
                  KIND_SEARCH, KIND_UPDATE, KIND_DELETE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_STATUS: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_next.status = status_ff;
               rsp_next.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end

         S_ADD: begin
            if (out_free) begin
               ram_ctl.wr_en          = 1'b1;
               ram_ctl.wr_addr        = IDX_W'(fill_ff);
               ram_ctl.wr_data.key    = req_ff.record_key;
               ram_ctl.wr_data.name   = req_ff.name_tag;
               ram_ctl.wr_data.amount = req_ff.amount;
               ram_ctl.wr_data.price  = req_ff.price_word;
               rsp_load               = 1'b1;
               rsp_next.status        = STAT_OK;
               rsp_next.slot          = SLOT_W'(fill_ff);
               rsp_next.out_key       = req_ff.record_key;
               rsp_next.out_name      = req_ff.name_tag;
               rsp_next.out_amount    = req_ff.amount;
               rsp_next.out_price     = req_ff.price_word;
               rsp_next.last          = 1'b1;
               fill_in                = fill_ff + CNT_W'(1);
               state_in               = S_IDLE;
            end
         end

         S_LIST_RD: begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = IDX_W'(idx_ff);
            state_in        = S_LIST_WAIT;
         end

         S_LIST_WAIT: begin
            // read data holds while the output stage is busy
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_next.status     = STAT_OK;
               rsp_next.slot       = SLOT_W'(idx_ff);
               rsp_next.out_key    = ram_rd_data.key;
               rsp_next.out_name   = ram_rd_data.name;
               rsp_next.out_amount = ram_rd_data.amount;
               rsp_next.out_price  = ram_rd_data.price;
               rsp_next.last       = list_last;
               if (list_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_LIST_RD;
               end
            end
         end

         S_SCAN: begin
            // compare entry idx-1 while fetching entry idx
            if (key_hit) begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = S_HIT;
            end else if (idx_ff < fill_ff) begin
               ram_ctl.rd_en   = 1'b1;
               ram_ctl.rd_addr = IDX_W'(idx_ff);
               idx_in          = idx_ff + CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               status_in = STAT_MISS;
               state_in  = S_STATUS;
            end
         end

         S_HIT: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_next.status     = STAT_OK;
               rsp_next.slot       = SLOT_W'(idx_ff);
               rsp_next.out_key    = ram_rd_data.key;
               rsp_next.out_name   = ram_rd_data.name;
               rsp_next.out_amount = ram_rd_data.amount;
               rsp_next.out_price  = ram_rd_data.price;
               rsp_next.last       = 1'b1;
               state_in            = S_IDLE;
               case (req_ff.kind)
                  KIND_UPDATE: begin
                     rsp_next.out_name      = req_ff.name_tag;
                     rsp_next.out_amount    = req_ff.amount;
                     rsp_next.out_price     = req_ff.price_word;
                     ram_ctl.wr_en          = 1'b1;
                     ram_ctl.wr_addr        = IDX_W'(idx_ff);
                     ram_ctl.wr_data.key    = ram_rd_data.key;
                     ram_ctl.wr_data.name   = req_ff.name_tag;
                     ram_ctl.wr_data.amount = req_ff.amount;
                     ram_ctl.wr_data.price  = req_ff.price_word;
                  end
                  KIND_DELETE: begin
                     if (next_pos < fill_ff) begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = IDX_W'(next_pos);
                        state_in        = S_SHIFT;
                     end else begin
                        fill_in = fill_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // move entry idx+1 down to idx, fetch idx+2
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = IDX_W'(idx_ff);
            ram_ctl.wr_data = ram_rd_data;
            idx_in          = next_pos;
            if (shift_next < (CNT_W+1)'(fill_ff)) begin
               ram_ctl.rd_en   = 1'b1;
               ram_ctl.rd_addr = IDX_W'(shift_next);
            end else begin
               fill_in  = fill_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
         req_ff    <= req_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_record_table_unit.sv
// Top level of the keyed record table: sequencer, record RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keyed record table: an unsorted table of up to CAPACITY records (key, 8-byte
// name tag, quantity, price word), searched linearly by key.
// Request channel (req_valid/req_ready/req_data): one command per request:
// add, list, search, update or delete. Codes 5 to 7 are dropped with no result.
// Result channel (rsp_valid/rsp_ready/rsp_data): one result per request, or one
// per stored record for list (at most 64); last marks the final one.
// The block works on one request at a time; req_ready is high only while idle.
// All records live in one RAM with a single read and a single write port, and
// that read port sets the order of work:
//   search/update/delete: one entry read per cycle, pipelined compare; delete
//   then shifts the later records down, one per cycle, after its result, and
//   the block stays busy until the shift is done
//   list: each record is read, then its result is loaded, before the next read.
// A finished result waits in the output register; while it is stalled the
// sequencer holds its next result and goes on once the register is free.
// Reset empties the table (fill count to zero) and drops any pending result;
// record contents are not cleared, nothing is read beyond the fill count.
module keyed_record_table_unit
   import krt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ram_ctl_type      ram_ctl;
   logic [REC_W-1:0] ram_rd_data;
   logic             rsp_load;
   rsp_type          rsp_next;
   logic             out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   // the output register can take a new result when empty or draining now
   assign out_free = !rsp_valid_ff || rsp_ready;

   krt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_next    (rsp_next),
      .ram_ctl     (ram_ctl),
      .ram_rd_data (rec_type'(ram_rd_data))
   );

   krt_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (REC_W'(ram_ctl.wr_data)),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Load a new result, drop a taken one, otherwise hold.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_record_table_chk.sv
// Port-level assertions for the keyed record table and their bind.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table_chk
   import krt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic req_fire;
   logic req_known;

   assign req_fire  = req_valid && req_ready;
   assign req_known = (req_data.kind == KIND_ADD) || (req_data.kind == KIND_LIST)
                      || (req_data.kind == KIND_SEARCH) || (req_data.kind == KIND_UPDATE)
                      || (req_data.kind == KIND_DELETE);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_known |=> !req_ready)
      else $error("ready again right after a command");

   a_drop_unknown: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_known |=> req_ready && !$rose(rsp_valid))
      else $error("unknown command produced a result or stalled");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_OK) |->
         rsp_data.last && (rsp_data.slot == '0) && (rsp_data.out_key == '0)
         && (rsp_data.out_name == '0) && (rsp_data.out_amount == '0)
         && (rsp_data.out_price == '0))
      else $error("status result carries record data or lacks last");

endmodule

bind keyed_record_table_unit keyed_record_table_chk u_chk (.*);

`default_nettype wire

FILE: tb/keyed_record_checker.sv
`timescale 1ns / 1ps
// Result checker of the keyed record table: predicts every result from the requests it sees.
module keyed_record_checker
   import krt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  req_type   req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  rsp_type   rsp_data,
   output int        fail_count,
   output int        pending_count,
   output int        request_count,
   output int        result_count,
   output int        peak_fill,
   output int        full_rejects
);

   localparam int MAX_SHOWN = 40;

   rec_type records [CAPACITY];
   int      fill;
   rsp_type expected_results [$];

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_SHOWN) begin
         $display("%0t ns: mismatch on result %0d: %s", $time, result_count, msg);
      end
      fail_count++;
   endtask

   function automatic void push_status(input logic [1:0] status);
      rsp_type res;
      res        = '0;
      res.status = status;
      res.last   = 1'b1;
      expected_results.push_back(res);
   endfunction

   function automatic void push_record(input int pos, input logic is_last);
      rsp_type res;
      res.status     = STAT_OK;
      res.slot       = 6'(pos);
      res.out_key    = records[pos].key;
      res.out_name   = records[pos].name;
      res.out_amount = records[pos].amount;
      res.out_price  = records[pos].price;
      res.last       = is_last;
      expected_results.push_back(res);
   endfunction

   // Walk the table the way the block does and queue the results one request causes.
   task automatic predict_results(input req_type cmd);
      int pos;
      int count;
      int i;
      pos = -1;
      case (cmd.kind)
         KIND_ADD: begin
            if (fill >= CAPACITY) begin
               push_status(STAT_FULL);
               full_rejects++;
            end else begin
               records[fill] = '{key: cmd.record_key, name: cmd.name_tag,
                                 amount: cmd.amount, price: cmd.price_word};
               push_record(fill, 1'b1);
               fill++;
            end
         end
         KIND_LIST: begin
            if (fill == 0) begin
               push_status(STAT_EMPTY);
            end else begin
               count = (fill < LIST_MAX) ? fill : LIST_MAX;
               for (i = 0; i < count; i++) push_record(i, i == count - 1);
            end
         end
         KIND_SEARCH, KIND_UPDATE, KIND_DELETE: begin
            // scan downward so the first match wins
            for (i = fill - 1; i >= 0; i--) begin
               if (records[i].key == cmd.record_key) pos = i;
            end
            if (pos < 0) begin
               push_status(STAT_MISS);
            end else begin
               if (cmd.kind == KIND_UPDATE) begin
                  records[pos].name   = cmd.name_tag;
                  records[pos].amount = cmd.amount;
                  records[pos].price  = cmd.price_word;
               end
               push_record(pos, 1'b1);
               if (cmd.kind == KIND_DELETE) begin
                  for (i = pos; i < fill - 1; i++) records[i] = records[i + 1];
                  fill--;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill = 0;
         expected_results.delete();
         fail_count    = 0;
         request_count = 0;
         result_count  = 0;
         peak_fill     = 0;
         full_rejects  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("none expected (status %0d, slot %0d, key %0d)",
                                         rsp_data.status, rsp_data.slot, rsp_data.out_key));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d",
                                            rsp_data.slot, want.slot));
               if (rsp_data.out_key !== want.out_key)
                  report_mismatch($sformatf("key %h, expected %h",
                                            rsp_data.out_key, want.out_key));
               if (rsp_data.out_name !== want.out_name)
                  report_mismatch($sformatf("name %h, expected %h",
                                            rsp_data.out_name, want.out_name));
               if (rsp_data.out_amount !== want.out_amount)
                  report_mismatch($sformatf("amount %h, expected %h",
                                            rsp_data.out_amount, want.out_amount));
               if (rsp_data.out_price !== want.out_price)
                  report_mismatch($sformatf("price %h, expected %h",
                                            rsp_data.out_price, want.out_price));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_data.last, want.last));
            end
            result_count++;
         end
         if (req_valid && req_ready) begin
            request_count++;
            predict_results(req_data);
         end
         if (fill > peak_fill) peak_fill = fill;
      end
      pending_count = expected_results.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the keyed record table testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module testbench;
   import krt_pkg::*;

   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_COUNT  = 150;
   // the random part opens with an add-heavy stretch that drives the table full
   localparam int FILL_STRETCH  = 90;
   // from this random request on neither side idles
   localparam int CALM_FROM     = 125;
   localparam int LONG_HOLD     = 300;
   // a delete at the front of a full table keeps shifting after its result
   localparam int SETTLE_CYCLES = 300;
   localparam int LIMIT_NS      = 4_000_000;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int request_count;
   int result_count;
   int peak_fill;
   int full_rejects;

   // calm and hold_output are shared between the request side and the result side
   bit calm        = 1'b0;
   bit hold_output = 1'b0;
   int steady_sends = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   keyed_record_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   keyed_record_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .request_count (request_count),
      .result_count  (result_count),
      .peak_fill     (peak_fill),
      .full_rejects  (full_rejects)
   );

   // Offer one request and hold it until the block takes it. Valid stays high across
   // back-to-back requests; it only drops when the task inserts an idle gap.
   task automatic send_request(input logic [2:0] kind, input logic signed [31:0] key,
                               input logic [63:0] name, input logic signed [31:0] amount,
                               input logic [31:0] price);
      req_type item;
      item = '{kind: kind, record_key: key, name_tag: name, amount: amount,
               price_word: price};
      if (steady_sends > 0) begin
         steady_sends--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end else if ($urandom_range(0, 7) == 0) begin
         // start a stretch of back-to-back requests
         steady_sends = $urandom_range(8, 24);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Result side: short random stalls, runs of steady acceptance, and one long hold-off
   // that lets the block back up until it refuses requests.
   initial begin : result_drain
      bit hold_taken;
      hold_taken = 1'b0;
      forever begin
         if (hold_output && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : 1) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic signed [31:0] key_pool [8];
      logic [2:0]         kind;
      logic signed [31:0] key;
      logic [63:0]        name;
      int                 roll;
      int                 add_cut;
      int                 search_cut;
      int                 update_cut;
      int                 delete_cut;

      // a small key pool keeps hits and duplicate keys common
      key_pool = '{KEY_MIN, KEY_MAX, 32'sd0, -32'sd1, $urandom, $urandom, $urandom, $urandom};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every command on an empty table first
      send_request(KIND_LIST, 32'sd0, '0, 32'sd0, '0);
      send_request(KIND_SEARCH, 32'sd5, '0, 32'sd0, '0);
      send_request(KIND_UPDATE, 32'sd5, '1, 32'sd7, 32'h3f80_0000);
      send_request(KIND_DELETE, 32'sd5, '0, 32'sd0, '0);
      // field extremes, then a duplicate key
      send_request(KIND_ADD, KEY_MIN, '1, KEY_MAX, 32'hffff_ffff);
      send_request(KIND_ADD, KEY_MAX, '0, KEY_MIN, 32'h0000_0000);
      send_request(KIND_ADD, KEY_MIN, 64'h0000_0000_0070_7564, -32'sd1, 32'h3f80_0000);
      // unused codes: dropped with no result
      send_request(3'd5, KEY_MIN, {$urandom, $urandom}, $urandom, $urandom);
      send_request(3'd6, KEY_MAX, {$urandom, $urandom}, $urandom, $urandom);
      send_request(3'd7, 32'sd0, {$urandom, $urandom}, $urandom, $urandom);
      // first match wins among duplicates
      send_request(KIND_SEARCH, KEY_MIN, '0, 32'sd0, '0);
      send_request(KIND_UPDATE, KEY_MIN, 64'h0123_4567_89ab_cdef, 32'sd100, 32'h42c8_0000);
      send_request(KIND_SEARCH, 32'sd12345, '0, 32'sd0, '0);
      send_request(KIND_LIST, 32'sd0, '0, 32'sd0, '0);
      // delete the front record, then the duplicate behind it must have moved down
      send_request(KIND_DELETE, KEY_MIN, '0, 32'sd0, '0);
      send_request(KIND_SEARCH, KEY_MIN, '0, 32'sd0, '0);
      send_request(KIND_DELETE, KEY_MAX, '0, 32'sd0, '0);
      send_request(KIND_DELETE, KEY_MIN, '0, 32'sd0, '0);
      // single record: delete leaves the table empty again
      send_request(KIND_ADD, -32'sd1, 64'hfedc_ba98_7654_3210, 32'sd1, 32'h8000_0000);
      send_request(KIND_DELETE, -32'sd1, '0, 32'sd0, '0);
      send_request(KIND_LIST, 32'sd0, '0, 32'sd0, '0);
      send_request(KIND_ADD, 32'sd0, 64'h0000_0000_0000_0041, 32'sd0, 32'h0000_0001);

      // Random part: fill the table past capacity, then mix everything
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         calm = (n >= CALM_FROM);
         // back up the result side early, while adds keep coming
         if (n == 5) hold_output = 1'b1;
         if (n < FILL_STRETCH) begin
            add_cut = 88; search_cut = 92; update_cut = 95; delete_cut = 98;
         end else begin
            add_cut = 35; search_cut = 55; update_cut = 70; delete_cut = 94;
         end
         roll = $urandom_range(0, 99);
         if (n == FILL_STRETCH) begin
            // the table is full by now: list all of it
            kind = KIND_LIST;
         end else if (roll < 3) begin
            kind = 3'($urandom_range(5, 7));
         end else if (roll < add_cut) begin
            kind = KIND_ADD;
         end else if (roll < search_cut) begin
            kind = KIND_SEARCH;
         end else if (roll < update_cut) begin
            kind = KIND_UPDATE;
         end else if (roll < delete_cut) begin
            kind = KIND_DELETE;
         end else begin
            kind = KIND_LIST;
         end
         key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
         case ($urandom_range(0, 7))
            0: name = '0;
            1: name = '1;
            default: name = {$urandom, $urandom};
         endcase
         send_request(kind, key, name, $urandom, $urandom);
      end
      req_valid <= 1'b0;

      // drain, then give a trailing shift time to finish and expose stray results
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d results; the table peaked at %0d of %0d records.",
               request_count, result_count, peak_fill, CAPACITY);
      $display("Adds refused on a full table: %0d; result side held off once for %0d cycles.",
               full_rejects, LONG_HOLD);
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #LIMIT_NS;
      $display("Timed out with %0d results still outstanding.", pending_count);
      $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/krt_seq.sv
hw/rtl/keyed_record_table_unit.sv
hw/rtl/keyed_record_table_chk.sv
tb/keyed_record_checker.sv
tb/testbench.sv
